// ===== hw/rtl/rsdc_pkg.sv =====
`default_nettype none

package rsdc_pkg;

  // Default width of the sequence timers
  localparam int unsigned TIMER_BITS_DEF = 16;

  // Stream word layout
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REQUIRED_PRESSES = 3'd0,
    REG_TIMEOUT_TICKS    = 3'd1,
    REG_STROBE_DELAY     = 3'd2,
    REG_BLINK_TICKS      = 3'd3,
    REG_OPEN_TICKS       = 3'd4,
    REG_DEBOUNCE_TICKS   = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam logic [7:0]  RST_REQUIRED_PRESSES = 8'd5;
  localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd1500;
  localparam logic [15:0] RST_STROBE_DELAY     = 16'd200;
  localparam logic [15:0] RST_BLINK_TICKS      = 16'd30;
  localparam logic [15:0] RST_OPEN_TICKS       = 16'd300;
  localparam logic [7:0]  RST_DEBOUNCE_TICKS   = 8'd2;

  // Serial command and status characters
  localparam logic [7:0] CH_GREET     = 8'h49; // 'I'
  localparam logic [7:0] CH_RELEASE   = 8'h52; // 'R'
  localparam logic [7:0] CH_OPEN      = 8'h4F; // 'O'
  localparam logic [7:0] CH_TIMEOUT   = 8'h54; // 'T'
  localparam logic [7:0] CH_LOCK      = 8'h4C; // 'L'
  localparam logic [7:0] CH_UNLOCK    = 8'h55; // 'U'
  localparam logic [7:0] CH_STROBE_ON = 8'h53; // 'S'
  localparam logic [7:0] CH_STROBE_OFF = 8'h73; // 's'

  localparam logic [7:0] PRESS_MAX = 8'hFF;

  // One result word as it leaves the block
  typedef struct packed {
    logic                   tx_valid;
    logic [OUT_TDATA_W-1:0] data;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ring_sequence_door_controller.sv =====
`default_nettype none

// Ring-sequence door controller.
// One word on the s_axis channel is one timer tick: the button level and an
// optional serial command byte (s_axis_tuser marks the byte as present).
// Every accepted tick gives exactly one word on m_axis: door, LED and strobe
// levels and an optional status byte (m_axis_tuser marks it as present).
// The cfg channel writes the six configuration registers; cfg_ready is always high
// and writes are meant to happen only while no tick is in flight.
// Each result is registered, in the skid register while the receiver stalls.
// Throughput: one tick per cycle while s_axis_tready is high; the whole
// tick update is one pass of counter compares and mode updates between
// the state and the result register.
// When the receiver stalls, the result register holds and a skid register
// takes one more tick; s_axis_tready drops only while both are full.
// Reset (rst, synchronous) loads the register defaults, clears the sequence,
// unlocks, enables the strobe and arms the greeting, so the first idle tick
// answers with status 'I'.
module ring_sequence_door_controller #(
  parameter int unsigned TIMER_BITS = rsdc_pkg::TIMER_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // cfg word
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [rsdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rsdc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // tick word
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // [0] ring_level, [8:1] cmd_byte, [15:9] zero
  input  wire logic [rsdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] cmd_valid
  input  wire logic                               s_axis_tuser,
  // result word
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] door_drive, [1] led_drive, [2] strobe_drive, [10:3] tx_byte, [15:11] zero
  output      logic [rsdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [0] tx_valid
  output      logic                               m_axis_tuser
);

  import rsdc_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef enum logic [2:0] {
    M_IDLE,
    M_DEB1,
    M_DEB2,
    M_RELEASE,
    M_BLINK,
    M_OPEN
  } mode_t;

  // Configuration registers
  logic [7:0]  required_presses;
  logic [15:0] timeout_ticks;
  logic [15:0] strobe_delay_ticks;
  logic [15:0] blink_ticks;
  logic [15:0] open_ticks;
  logic [7:0]  debounce_ticks;

  // Controller state
  mode_t                 mode, mode_next;
  logic [15:0]           wait_counter, wait_counter_next;
  logic [7:0]            press_count, press_count_next;
  logic [TIMER_BITS-1:0] since_first, since_first_next;
  logic [TIMER_BITS-1:0] since_last, since_last_next;
  logic                  locked, locked_next;
  logic                  strobe_enabled, strobe_enabled_next;
  logic                  greeting_sent, greeting_sent_next;
  logic                  door_after_blink, door_after_blink_next;
  logic                  strobe_on, strobe_on_next;

  // Result registers
  logic out_valid, skid_valid;
  res_t out_res, skid_res, res_next;

  logic       ring;
  logic       cmd_valid;
  logic [7:0] cmd_byte;
  logic       accept_in;
  logic       take_out;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       door_drive;
  logic       led_drive;
  logic       do_idle;
  logic       do_rest;

  assign ring      = s_axis_tdata[0];
  assign cmd_byte  = s_axis_tdata[8:1];
  assign cmd_valid = s_axis_tuser;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = out_res.tx_valid;
  assign take_out      = out_valid && m_axis_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      required_presses   <= RST_REQUIRED_PRESSES;
      timeout_ticks      <= RST_TIMEOUT_TICKS;
      strobe_delay_ticks <= RST_STROBE_DELAY;
      blink_ticks        <= RST_BLINK_TICKS;
      open_ticks         <= RST_OPEN_TICKS;
      debounce_ticks     <= RST_DEBOUNCE_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REQUIRED_PRESSES: required_presses   <= cfg_data[7:0];
        REG_TIMEOUT_TICKS:    timeout_ticks      <= cfg_data;
        REG_STROBE_DELAY:     strobe_delay_ticks <= cfg_data;
        REG_BLINK_TICKS:      blink_ticks        <= cfg_data;
        REG_OPEN_TICKS:       open_ticks         <= cfg_data;
        REG_DEBOUNCE_TICKS:   debounce_ticks     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Work out one tick: timers, mode step, idle poll, then timeout, strobe delay or command
  always_comb begin
    mode_next             = mode;
    wait_counter_next     = wait_counter;
    press_count_next      = press_count;
    since_first_next      = since_first;
    since_last_next       = since_last;
    locked_next           = locked;
    strobe_enabled_next   = strobe_enabled;
    greeting_sent_next    = greeting_sent;
    door_after_blink_next = door_after_blink;
    strobe_on_next        = strobe_on;
    tx_valid              = 1'b0;
    tx_byte               = 8'd0;
    do_idle               = 1'b0;
    do_rest               = 1'b0;

    // advance sequence timers, saturating
    if (press_count != 8'd0) begin
      if (since_first != {TIMER_BITS{1'b1}}) since_first_next = since_first + TIMER_BITS'(1);
      if (since_last != {TIMER_BITS{1'b1}})  since_last_next  = since_last + TIMER_BITS'(1);
    end

    case (mode)
      M_DEB1, M_DEB2: begin
        if (wait_counter > 16'd1) begin
          wait_counter_next = wait_counter - 16'd1;
        end else if (ring) begin
          if (mode == M_DEB1) begin
            mode_next         = M_DEB2;
            wait_counter_next = {8'd0, debounce_ticks};
          end else begin
            mode_next = M_RELEASE;
          end
        end else begin
          mode_next = M_IDLE;
          do_rest   = 1'b1;
        end
      end
      M_RELEASE: begin
        // accept the press on release
        if (!ring) begin
          tx_valid  = 1'b1;
          tx_byte   = CH_RELEASE;
          mode_next = M_IDLE;
          if (!locked) begin
            if (press_count == 8'd0) since_first_next = '0;
            if (press_count != PRESS_MAX) press_count_next = press_count + 8'd1;
            door_after_blink_next = (press_count_next >= required_presses);
            mode_next             = M_BLINK;
            wait_counter_next     = blink_ticks;
          end
        end
      end
      M_BLINK: begin
        if (wait_counter > 16'd1) begin
          wait_counter_next = wait_counter - 16'd1;
        end else begin
          wait_counter_next = 16'd0;
          since_last_next   = '0;
          if (door_after_blink) begin
            strobe_on_next        = 1'b0;
            press_count_next      = 8'd0;
            since_first_next      = '0;
            door_after_blink_next = 1'b0;
            tx_valid              = 1'b1;
            tx_byte               = CH_OPEN;
            mode_next             = M_OPEN;
            wait_counter_next     = open_ticks;
          end else begin
            do_idle = 1'b1;
          end
        end
      end
      M_OPEN: begin
        if (wait_counter > 16'd1) begin
          wait_counter_next = wait_counter - 16'd1;
        end else begin
          wait_counter_next = 16'd0;
          do_idle           = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // idle poll: greeting, then button, then the rest
    if (do_idle) begin
      mode_next = M_IDLE;
      if (!greeting_sent) begin
        greeting_sent_next = 1'b1;
        tx_valid           = 1'b1;
        tx_byte            = CH_GREET;
      end else if (ring) begin
        if (debounce_ticks == 8'd0) begin
          mode_next = M_RELEASE;
        end else begin
          mode_next         = M_DEB1;
          wait_counter_next = {8'd0, debounce_ticks};
        end
      end else begin
        do_rest = 1'b1;
      end
    end

    // sequence timeout and strobe delay take the tick; else run the command
    if (do_rest) begin
      if ((press_count_next != 8'd0) &&
          (CMP_W'(since_first_next) >= CMP_W'(timeout_ticks))) begin
        tx_valid              = 1'b1;
        tx_byte               = CH_TIMEOUT;
        strobe_on_next        = 1'b0;
        press_count_next      = 8'd0;
        since_first_next      = '0;
        since_last_next       = '0;
        door_after_blink_next = 1'b0;
      end else if ((press_count_next != 8'd0) &&
                   (CMP_W'(since_last_next) >= CMP_W'(strobe_delay_ticks))) begin
        if (strobe_enabled) strobe_on_next = 1'b1;
      end else if (cmd_valid) begin
        case (cmd_byte)
          CH_OPEN: begin
            tx_valid          = 1'b1;
            tx_byte           = CH_OPEN;
            mode_next         = M_OPEN;
            wait_counter_next = open_ticks;
          end
          CH_LOCK: begin
            tx_valid    = 1'b1;
            tx_byte     = CH_LOCK;
            locked_next = 1'b1;
          end
          CH_UNLOCK: begin
            tx_valid    = 1'b1;
            tx_byte     = CH_UNLOCK;
            locked_next = 1'b0;
          end
          CH_STROBE_ON: begin
            tx_valid            = 1'b1;
            tx_byte             = CH_STROBE_ON;
            strobe_enabled_next = 1'b1;
          end
          CH_STROBE_OFF: begin
            tx_valid            = 1'b1;
            tx_byte             = CH_STROBE_OFF;
            strobe_on_next      = 1'b0;
            strobe_enabled_next = 1'b0;
          end
          default: ;
        endcase
      end
    end

    // drive levels from the new state
    door_drive = (mode_next == M_OPEN) && (wait_counter_next != 16'd0);
    led_drive  = !((mode_next == M_BLINK) && (wait_counter_next != 16'd0));

    res_next.tx_valid = tx_valid;
    res_next.data     = {5'd0, tx_byte, strobe_on_next, led_drive, door_drive};
  end

  // Hold controller state, advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= M_IDLE;
      wait_counter     <= 16'd0;
      press_count      <= 8'd0;
      since_first      <= '0;
      since_last       <= '0;
      locked           <= 1'b0;
      strobe_enabled   <= 1'b1;
      greeting_sent    <= 1'b0;
      door_after_blink <= 1'b0;
      strobe_on        <= 1'b0;
    end else if (accept_in) begin
      mode             <= mode_next;
      wait_counter     <= wait_counter_next;
      press_count      <= press_count_next;
      since_first      <= since_first_next;
      since_last       <= since_last_next;
      locked           <= locked_next;
      strobe_enabled   <= strobe_enabled_next;
      greeting_sent    <= greeting_sent_next;
      door_after_blink <= door_after_blink_next;
      strobe_on        <= strobe_on_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept_in;
      end else begin
        out_valid  <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  // Move result words
  always_ff @(posedge clk) begin
    if (take_out || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (accept_in) skid_res <= res_next;
      end else if (accept_in) begin
        out_res <= res_next;
      end
    end else if (accept_in) begin
      skid_res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_idle_seq_clear: assert property (@(posedge clk) disable iff (rst)
    (press_count == 8'd0) |-> (since_first == '0 && since_last == '0))
    else $error("sequence timers running with no press counted");

  a_door_not_blink: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.data[0] && !out_res.data[1]))
    else $error("door driven during a blink");

  a_tx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.tx_valid) |-> (out_res.data[10:3] == 8'd0))
    else $error("status byte set without tx_valid");
`endif

endmodule

`default_nettype wire
